// ===== hdl/tts_pkg.sv =====
package tts_pkg;

   typedef enum logic [1:0] {
      REQ_POLL  = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_START = 2'd2,
      REQ_ARM   = 2'd3
   } req_kind_type;

   localparam logic [1:0] CH_HEAD  = 2'd0;
   localparam logic [1:0] CH_TAIL  = 2'd1;
   localparam logic [1:0] CH_MOUTH = 2'd2;

   localparam logic [1:0] CSR_HEAD_COUNT  = 2'd0;
   localparam logic [1:0] CSR_TAIL_COUNT  = 2'd1;
   localparam logic [1:0] CSR_MOUTH_COUNT = 2'd2;

   localparam int NUM_CH   = 3;
   localparam int COUNT_W  = 7;
   localparam int TIME_W   = 32;
   localparam int ENTRY_W  = 6;

   typedef struct packed {
      logic head_drive;
      logic tail_drive;
      logic mouth_drive;
      logic finished;
      logic running;
   } rsp_data_type;

endpackage

// ===== hdl/tts_table.sv =====
module tts_table #(
   parameter int TABLE_DEPTH = 64,
   parameter int ADDR_W      = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tts_pkg::TIME_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tts_pkg::TIME_W-1:0] rd_data
);
   import tts_pkg::*;

   logic [TIME_W-1:0] mem [TABLE_DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-through so the prefetched entry never goes stale
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tts_out_buf.sv =====
module tts_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tts_pkg::rsp_data_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tts_pkg::rsp_data_type out_data
);
   import tts_pkg::*;

   logic         main_valid_ff;
   logic         main_valid_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   rsp_data_type main_ff;
   rsp_data_type main_in;
   rsp_data_type skid_ff;
   rsp_data_type skid_in;
   logic         push;
   logic         pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = in_data;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a main entry");

   a_stall_keeps_head: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready) |=> (main_valid_ff && $stable(main_ff)))
      else $error("stalled transaction changed");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (main_ff == $past(skid_ff)))
      else $error("skid entry not moved forward in order");

endmodule

// ===== hdl/timed_toggle_sequencer.sv =====
// Three-channel toggle sequencer for head, tail and mouth actuators.
// Request channel (req_*): one transaction per command. req_type selects poll,
// table load, start (clear indices, toggles, pins and running) or arm (clear indices
// and finished, enable play). A poll after arming latches req_now_ms as the
// start time; later polls fire each channel whose next table time has been
// reached by the elapsed time.
// Response channel (rsp_*): exactly one transaction per request, carrying the
// pin levels, finished and running flags after that request, in order.
// Config channel (csr_*): writes the three channel counts; always ready.
// Throughput: one request per cycle while the output stage has room. Each
// response is registered in the output stage. Each channel keeps the table
// entry at its current index prefetched in the memory's registered read
// port, addressed with the index's next value, so a poll never waits on a read.
// Receiver stall: a two-entry output stage holds responses; req_ready drops
// only when both entries are full and returns as soon as one is taken.
// Reset: synchronous; indices, toggles, pins, flags and counts clear. The time
// tables are not cleared and must be loaded before use.
module timed_toggle_sequencer #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_now_ms,
   input  logic [1:0]  req_channel,
   input  logic [5:0]  req_entry_index,
   input  logic [31:0] req_entry_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_head_drive,
   output logic        rsp_tail_drive,
   output logic        rsp_mouth_drive,
   output logic        rsp_finished,
   output logic        rsp_running,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import tts_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW     = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

   logic                accept;
   req_kind_type        kind;
   logic                do_load;
   logic                do_start;
   logic                do_arm;
   logic                do_latch;
   logic                do_check;
   logic                load_in_range;
   logic [TIME_W-1:0]   elapsed;

   logic [COUNT_W-1:0]  count_ff [NUM_CH];
   logic [COUNT_W-1:0]  count_in [NUM_CH];
   logic [IDX_W-1:0]    idx_ff   [NUM_CH];
   logic [IDX_W-1:0]    idx_in   [NUM_CH];
   logic [IDX_W-1:0]    idx_rd   [NUM_CH];
   logic [CW-1:0]       lim      [NUM_CH];
   logic [TIME_W-1:0]   due_time [NUM_CH];
   logic                tbl_wr   [NUM_CH];
   logic [NUM_CH-1:0]   fire;
   logic [NUM_CH-1:0]   done;

   logic [NUM_CH-1:0]   toggle_ff;
   logic [NUM_CH-1:0]   toggle_in;
   logic [NUM_CH-1:0]   pin_ff;
   logic [NUM_CH-1:0]   pin_in;
   logic [TIME_W-1:0]   start_ff;
   logic [TIME_W-1:0]   start_in;
   logic                playing_ff;
   logic                playing_in;
   logic                idle_wait_ff;
   logic                idle_wait_in;
   logic                armed_ff;
   logic                armed_in;

   logic                buf_ready;
   rsp_data_type        rsp_in;
   rsp_data_type        rsp_out;

   assign req_ready = buf_ready;
   assign accept    = req_valid && buf_ready;
   assign kind      = req_kind_type'(req_type);
   assign csr_ready = 1'b1;

   assign load_in_range = 32'(req_entry_index) < 32'(TABLE_DEPTH);
   assign do_load  = accept && (kind == REQ_LOAD) && load_in_range;
   assign do_start = accept && (kind == REQ_START);
   assign do_arm   = accept && (kind == REQ_ARM);
   assign do_latch = accept && (kind == REQ_POLL) && !idle_wait_ff && armed_ff && !playing_ff;
   assign do_check = accept && (kind == REQ_POLL) && !idle_wait_ff && armed_ff && playing_ff;
   assign elapsed  = req_now_ms - start_ff;

   assign tbl_wr[CH_HEAD]  = do_load && (req_channel == CH_HEAD);
   assign tbl_wr[CH_TAIL]  = do_load && (req_channel == CH_TAIL);
   assign tbl_wr[CH_MOUTH] = do_load && (req_channel == CH_MOUTH);

   for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
      assign lim[c] = (CW'(count_ff[c]) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                            : CW'(count_ff[c]);
      assign fire[c] = do_check && (CW'(idx_ff[c]) < lim[c]) && (elapsed >= due_time[c]);

      always_comb begin
         if (do_start || do_arm) begin
            idx_in[c] = '0;
         end else if (fire[c]) begin
            idx_in[c] = idx_ff[c] + IDX_W'(1);
         end else begin
            idx_in[c] = idx_ff[c];
         end
      end

      assign done[c]   = CW'(idx_in[c]) >= lim[c];
      assign idx_rd[c] = reset ? '0 : idx_in[c];

      tts_table #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .ADDR_W      (ADDR_W)
      ) u_table (
         .clock   (clock),
         .wr_en   (tbl_wr[c]),
         .wr_addr (ADDR_W'(req_entry_index)),
         .wr_data (req_entry_time),
         .rd_addr (idx_rd[c][ADDR_W-1:0]),
         .rd_data (due_time[c])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HEAD_COUNT:  count_in[CH_HEAD]  = csr_wdata;
            CSR_TAIL_COUNT:  count_in[CH_TAIL]  = csr_wdata;
            CSR_MOUTH_COUNT: count_in[CH_MOUTH] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      toggle_in    = toggle_ff;
      pin_in       = pin_ff;
      start_in     = start_ff;
      playing_in   = playing_ff;
      idle_wait_in = idle_wait_ff;
      armed_in     = armed_ff;
      if (do_start) begin
         toggle_in  = '0;
         pin_in     = '0;
         playing_in = 1'b0;
      end
      if (do_arm) begin
         idle_wait_in = 1'b0;
         armed_in     = 1'b1;
      end
      if (do_latch) begin
         start_in   = req_now_ms;
         playing_in = 1'b1;
      end
      // head and tail exclude each other; tail wins when both fire
      if (fire[CH_HEAD]) begin
         toggle_in[CH_HEAD] = !toggle_in[CH_HEAD];
         pin_in[CH_HEAD]    = toggle_in[CH_HEAD];
         pin_in[CH_TAIL]    = 1'b0;
      end
      if (fire[CH_TAIL]) begin
         toggle_in[CH_TAIL] = !toggle_in[CH_TAIL];
         pin_in[CH_TAIL]    = toggle_in[CH_TAIL];
         pin_in[CH_HEAD]    = 1'b0;
      end
      if (fire[CH_MOUTH]) begin
         toggle_in[CH_MOUTH] = !toggle_in[CH_MOUTH];
         pin_in[CH_MOUTH]    = toggle_in[CH_MOUTH];
      end
      if (do_check && (&done)) begin
         playing_in   = 1'b0;
         idle_wait_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '{default: '0};
         idx_ff       <= '{default: '0};
         toggle_ff    <= '0;
         pin_ff       <= '0;
         start_ff     <= '0;
         playing_ff   <= 1'b0;
         idle_wait_ff <= 1'b0;
         armed_ff     <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         toggle_ff    <= toggle_in;
         pin_ff       <= pin_in;
         start_ff     <= start_in;
         playing_ff   <= playing_in;
         idle_wait_ff <= idle_wait_in;
         armed_ff     <= armed_in;
      end
   end

   assign rsp_in.head_drive  = pin_in[CH_HEAD];
   assign rsp_in.tail_drive  = pin_in[CH_TAIL];
   assign rsp_in.mouth_drive = pin_in[CH_MOUTH];
   assign rsp_in.finished    = idle_wait_in;
   assign rsp_in.running     = playing_in;

   tts_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (buf_ready),
      .in_data   (rsp_in),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_out)
   );

   assign rsp_head_drive  = rsp_out.head_drive;
   assign rsp_tail_drive  = rsp_out.tail_drive;
   assign rsp_mouth_drive = rsp_out.mouth_drive;
   assign rsp_finished    = rsp_out.finished;
   assign rsp_running     = rsp_out.running;

   a_not_both_flags: assert property (@(posedge clock) disable iff (reset)
      !(playing_ff && idle_wait_ff))
      else $error("finished and running both set");

   a_idx_bounded: assert property (@(posedge clock) disable iff (reset)
      (32'(idx_ff[CH_HEAD]) <= 32'(TABLE_DEPTH)) && (32'(idx_ff[CH_TAIL]) <= 32'(TABLE_DEPTH))
      && (32'(idx_ff[CH_MOUTH]) <= 32'(TABLE_DEPTH)))
      else $error("channel index past table depth");

   a_head_tail_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(pin_ff[CH_HEAD] && pin_ff[CH_TAIL]))
      else $error("head and tail driven together");

   a_fire_needs_play: assert property (@(posedge clock) disable iff (reset)
      (|fire) |=> (idle_wait_ff || playing_ff))
      else $error("toggle fired outside a running sequence");

endmodule
